/* hdl/lts_pkg.sv */
// shared types and constants for the line and token splitter
`default_nettype none

package lts_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned NumDelim = 4;
  localparam int unsigned CountW   = 3;

  localparam logic [ByteW-1:0] ByteCr = 8'd13;
  localparam logic [ByteW-1:0] ByteLf = 8'd10;
  localparam logic [ByteW-1:0] TokMax = 8'd255;

  typedef enum logic [1:0] {
    CLASS_TEXT     = 2'd0,
    CLASS_DELIM    = 2'd1,
    CLASS_LINE_END = 2'd2,
    CLASS_CONT     = 2'd3
  } byte_class_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HTTP_MODE   = 3'd0,
    REG_DELIM_COUNT = 3'd1,
    REG_DELIM_A     = 3'd2,
    REG_DELIM_B     = 3'd3,
    REG_DELIM_C     = 3'd4,
    REG_DELIM_D     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                          http_mode;
    logic [CountW-1:0]             delim_count;
    logic [NumDelim-1:0][ByteW-1:0] delim;
  } cfg_t;

  typedef struct packed {
    logic             prev_terminator;
    logic             prev_cr_end;
    logic             prev_delimiter;
    logic             line_fresh;
    logic [ByteW-1:0] token_count;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    byte_class_e      byte_class;
    logic             token_begin;
    logic [ByteW-1:0] token_number;
  } result_t;

endpackage

`default_nettype wire

/* hdl/lts_cfg_regs.sv */
// configuration register file for the line and token splitter
`default_nettype none

module lts_cfg_regs
  import lts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HTTP_MODE:   cfg_d.http_mode   = cfg_data_i[0];
        REG_DELIM_COUNT: cfg_d.delim_count = cfg_data_i[CountW-1:0];
        REG_DELIM_A:     cfg_d.delim[0]    = cfg_data_i;
        REG_DELIM_B:     cfg_d.delim[1]    = cfg_data_i;
        REG_DELIM_C:     cfg_d.delim[2]    = cfg_data_i;
        REG_DELIM_D:     cfg_d.delim[3]    = cfg_data_i;
        default:         cfg_d = cfg_q;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.http_mode   <= 1'b0;
      cfg_q.delim_count <= 3'd1;
      cfg_q.delim[0]    <= 8'd32;
      cfg_q.delim[1]    <= 8'd9;
      cfg_q.delim[2]    <= 8'd0;
      cfg_q.delim[3]    <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/lts_classify.sv */
// byte classification and next-state logic for one byte
`default_nettype none

module lts_classify
  import lts_pkg::*;
(
  input  wire logic [ByteW-1:0] byte_i,
  input  cfg_t                  cfg_i,
  input  state_t                state_i,
  output result_t               res_o,
  output state_t                state_o
);

  logic             is_term;
  logic             cont;
  logic             is_delim;
  logic             list_open;
  logic [CountW-1:0] n_used;
  logic [ByteW-1:0] tok_next;

  // delimiter list: a zero entry closes the list
  always_comb begin
    n_used    = (cfg_i.delim_count > CountW'(NumDelim)) ? CountW'(NumDelim)
                                                        : cfg_i.delim_count;
    is_delim  = 1'b0;
    list_open = 1'b1;
    for (int i = 0; i < NumDelim; i++) begin
      if (CountW'(i) < n_used && list_open) begin
        if (cfg_i.delim[i] == '0) begin
          list_open = 1'b0;
        end else if (cfg_i.delim[i] == byte_i) begin
          is_delim  = 1'b1;
          list_open = 1'b0;
        end
      end
    end
  end

  always_comb begin
    is_term  = (byte_i == ByteCr) || (byte_i == ByteLf);
    cont     = cfg_i.http_mode ? (state_i.prev_cr_end && byte_i == ByteLf)
                               : state_i.prev_terminator;
    tok_next = state_i.token_count;
    res_o    = '0;
    state_o  = state_i;

    if (is_term) begin
      res_o.out_byte       = '0;
      res_o.byte_class     = cont ? CLASS_CONT : CLASS_LINE_END;
      res_o.token_begin    = 1'b0;
      res_o.token_number   = state_i.token_count;
      state_o.prev_cr_end     = !cont && (byte_i == ByteCr);
      state_o.prev_terminator = 1'b1;
      state_o.prev_delimiter  = 1'b0;
      state_o.line_fresh      = 1'b1;
      state_o.token_count     = '0;
    end else begin
      if (state_i.line_fresh) begin
        res_o.token_begin = 1'b1;
        tok_next          = '0;
      end else if (!is_delim && state_i.prev_delimiter) begin
        res_o.token_begin = 1'b1;
        if (state_i.token_count != TokMax) begin
          tok_next = state_i.token_count + ByteW'(1);
        end
      end
      res_o.out_byte     = is_delim ? '0 : byte_i;
      res_o.byte_class   = is_delim ? CLASS_DELIM : CLASS_TEXT;
      res_o.token_number = tok_next;
      state_o.prev_delimiter  = is_delim;
      state_o.prev_terminator = 1'b0;
      state_o.prev_cr_end     = 1'b0;
      state_o.line_fresh      = 1'b0;
      state_o.token_count     = tok_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/line_and_token_splitter.sv */
// top level of the line and token splitter: input register, classifier, result register
// a taken request is held in the input register and moves into the result register when that is free
// throughput: one byte per cycle; the input stalls only while the result register is full
// and not being drained in that cycle
// the only loop is the one-byte history (terminator, delimiter, token count) in the classifier
// reset: asynchronous, active low; clears both valid flags, sets history and config to defaults
`default_nettype none

module line_and_token_splitter
  import lts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input requests
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [ByteW-1:0]    data_byte_i,
  // result requests
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [ByteW-1:0]    out_byte_o,
  output      logic [1:0]          byte_class_o,
  output      logic                token_begin_o,
  output      logic [ByteW-1:0]    token_number_o
);

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t res_d, res_q;

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             out_valid_q;
  logic             out_free;
  logic             advance;

  lts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lts_classify u_classify (
    .byte_i  (byte_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .res_o   (res_d),
    .state_o (state_d)
  );

  // the result register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;
  // a held byte moves into the result register and commits its history update
  assign advance  = in_valid_q && out_free;
  // the input register takes a new request when empty or emptying
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{prev_terminator: 1'b0, prev_cr_end: 1'b0,
                       prev_delimiter: 1'b0, line_fresh: 1'b1,
                       token_count: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = res_q.out_byte;
  assign byte_class_o   = res_q.byte_class;
  assign token_begin_o  = res_q.token_begin;
  assign token_number_o = res_q.token_number;

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the line and token splitter: byte stream in, classified bytes out
`timescale 1ns / 1ps

module tb;
  import lts_pkg::*;

  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned PhaseBytes    = 95;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned SatTokens     = 300;
  // indexes past the register list, the block must ignore writes to them
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  // dut inputs, all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [ByteW-1:0]    out_byte_o;
  logic [1:0]          byte_class_o;
  logic                token_begin_o;
  logic [ByteW-1:0]    token_number_o;

  // byte stream waiting to be offered, and classifications still owed by the block
  logic [ByteW-1:0] byte_stream[$];
  result_t          owed_class[$];

  // knobs the sequencer turns per phase
  int unsigned src_idle_pct = 20;
  int unsigned snk_idle_pct = 20;
  bit          hold_req     = 1'b0;

  bit          in_taken    = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count    = 0;

  // shadow of the configuration registers
  logic             sh_http = 1'b0;
  logic [2:0]       sh_count = 3'd1;
  logic [ByteW-1:0] sh_delim[NumDelim] = '{8'd32, 8'd9, 8'd0, 8'd0};

  // splitter history as the block should hold it
  bit               st_term   = 1'b0;
  bit               st_cr_end = 1'b0;
  bit               st_delim  = 1'b0;
  bit               st_fresh  = 1'b1;
  logic [ByteW-1:0] st_tok    = '0;

  line_and_token_splitter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_class_o   (byte_class_o),
    .token_begin_o  (token_begin_o),
    .token_number_o (token_number_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // number of delimiter registers actually live: count capped at four, cut at the first zero
  function automatic int unsigned live_delims();
    int unsigned n;
    int unsigned k;
    n = (sh_count > 3'd4) ? 4 : sh_count;
    k = 0;
    while (k < n && sh_delim[k] != 8'd0) k++;
    return k;
  endfunction

  function automatic bit delim_match(input logic [ByteW-1:0] b);
    int unsigned n;
    bit hit;
    n = live_delims();
    hit = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (sh_delim[i] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // classify one byte and advance the line/token history
  function automatic result_t split_byte(input logic [ByteW-1:0] b);
    result_t r;
    bit cont;
    bit hit;
    r.out_byte    = b;
    r.token_begin = 1'b0;
    if (b == ByteCr || b == ByteLf) begin
      // http: only an lf right after a line-ending cr continues it; plain: whole run is one
      cont = sh_http ? (st_cr_end && b == ByteLf) : st_term;
      r.byte_class   = cont ? CLASS_CONT : CLASS_LINE_END;
      r.out_byte     = '0;
      r.token_number = st_tok;
      st_cr_end = !cont && b == ByteCr;
      st_term   = 1'b1;
      st_delim  = 1'b0;
      st_fresh  = 1'b1;
      st_tok    = '0;
    end else begin
      hit = delim_match(b);
      if (st_fresh) begin
        // first body byte of a line opens token 0, even when it is a delimiter
        r.token_begin = 1'b1;
        st_tok = '0;
      end else if (!hit && st_delim) begin
        r.token_begin = 1'b1;
        if (st_tok != TokMax) st_tok = st_tok + 8'd1;
      end
      r.byte_class   = hit ? CLASS_DELIM : CLASS_TEXT;
      if (hit) r.out_byte = '0;
      r.token_number = st_tok;
      st_delim  = hit;
      st_term   = 1'b0;
      st_cr_end = 1'b0;
      st_fresh  = 1'b0;
    end
    return r;
  endfunction

  // body byte that is neither a terminator nor a live delimiter, mostly printable
  function automatic logic [ByteW-1:0] text_byte();
    logic [ByteW-1:0] b;
    do begin
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h21, 8'h7e)) : 8'($urandom);
    end while (b == ByteCr || b == ByteLf || delim_match(b));
    return b;
  endfunction

  // one of the live delimiters, or any byte when none is live
  function automatic logic [ByteW-1:0] delim_byte();
    int unsigned n;
    n = live_delims();
    if (n == 0) return 8'($urandom);
    return sh_delim[$urandom_range(0, n - 1)];
  endfunction

  task automatic push_delims();
    repeat ($urandom_range(1, 3)) byte_stream.push_back(delim_byte());
  endtask

  // a well-formed line: optional leading run, tokens split by delimiter runs,
  // optional trailing run, then some flavour of terminator
  task automatic queue_line(input int unsigned ntok, input int unsigned max_len);
    if ($urandom_range(0, 9) == 0) push_delims();
    for (int unsigned k = 0; k < ntok; k++) begin
      repeat ($urandom_range(1, max_len)) byte_stream.push_back(text_byte());
      if (k + 1 < ntok) push_delims();
    end
    if ($urandom_range(0, 5) == 0) push_delims();
    case ($urandom_range(0, 4))
      0: byte_stream.push_back(ByteCr);
      1: byte_stream.push_back(ByteLf);
      2: begin
        byte_stream.push_back(ByteCr);
        byte_stream.push_back(ByteLf);
      end
      3: begin
        byte_stream.push_back(ByteCr);
        byte_stream.push_back(ByteLf);
        byte_stream.push_back(ByteCr);
        byte_stream.push_back(ByteLf);
      end
      default: begin
        byte_stream.push_back(ByteLf);
        byte_stream.push_back(ByteCr);
      end
    endcase
  endtask

  // a phase's worth of mostly well-formed lines with some raw noise mixed in
  task automatic queue_random();
    while (byte_stream.size() < PhaseBytes) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_line($urandom_range(0, 6), 4);
      end else begin
        repeat ($urandom_range(1, 8)) byte_stream.push_back(8'($urandom));
      end
    end
  endtask

  // one register write, shadow updated alongside; caller lowers the enable afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_HTTP_MODE:   sh_http     = val[0];
      REG_DELIM_COUNT: sh_count    = val[2:0];
      REG_DELIM_A:     sh_delim[0] = val;
      REG_DELIM_B:     sh_delim[1] = val;
      REG_DELIM_C:     sh_delim[2] = val;
      REG_DELIM_D:     sh_delim[3] = val;
      default: ;
    endcase
  endtask

  // full register set plus one write to a spare index; junk in the unused upper bits of mode and count
  task automatic set_config(input logic http, input logic [2:0] count,
                            input logic [ByteW-1:0] da, input logic [ByteW-1:0] db,
                            input logic [ByteW-1:0] dc, input logic [ByteW-1:0] dd);
    logic [CfgDataW-1:0] v;
    v = 8'($urandom);
    v[0] = http;
    write_reg(REG_HTTP_MODE, v);
    v = 8'($urandom);
    v[2:0] = count;
    write_reg(REG_DELIM_COUNT, v);
    write_reg(REG_DELIM_A, da);
    write_reg(REG_DELIM_B, db);
    write_reg(REG_DELIM_C, dc);
    write_reg(REG_DELIM_D, dd);
    write_reg(($urandom_range(0, 1) == 0) ? RegSpareLo : RegSpareHi, 8'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender stops and waits until every owed classification has come back;
  // checked at the rising edge, where the sender's outputs are settled
  task automatic drain();
    do @(posedge clk_i);
    while (byte_stream.size() != 0 || in_valid_i || owed_class.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // sender: offers the next byte at the falling edge, holds it until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (byte_stream.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= byte_stream.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off counted here
  always @(negedge clk_i) begin : receiver
    int unsigned hold_left;
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_left   = LongHold;
      hold_req    = 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // monitor: predicts on each taken byte, checks each returned classification
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    bit took_in;
    bit took_out;
    took_in  = rst_ni && in_valid_i && in_ready_o;
    took_out = rst_ni && out_valid_o && out_ready_i;
    in_taken     <= took_in;
    quiet_cycles <= (took_in || took_out) ? 0 : quiet_cycles + 1;
    if (took_in) owed_class.push_back(split_byte(data_byte_i));
    if (took_out) begin
      got.out_byte     = out_byte_o;
      got.byte_class   = byte_class_e'(byte_class_o);
      got.token_begin  = token_begin_o;
      got.token_number = token_number_o;
      if (owed_class.size() == 0) begin
        err_count++;
        if (err_count <= MaxReported)
          $display("%0t: unexpected result byte=%02h class=%0d begin=%0b token=%0d",
                   $realtime, got.out_byte, got.byte_class, got.token_begin, got.token_number);
      end else begin
        want = owed_class.pop_front();
        if (got.out_byte != want.out_byte || got.byte_class != want.byte_class ||
            got.token_begin != want.token_begin || got.token_number != want.token_number) begin
          err_count++;
          if (err_count <= MaxReported)
            $display("%0t: mismatch byte/class/begin/token exp %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
                     $realtime, want.out_byte, want.byte_class, want.token_begin,
                     want.token_number, got.out_byte, got.byte_class, got.token_begin,
                     got.token_number);
        end
      end
    end
  end

  // watchdog: too long without any request moving on either side
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("line_and_token_splitter verification failed");
    $finish;
  end

  // sequencer: reset, directed bytes, then randomised phases under varied settings
  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings, plain mode, space as the only delimiter: leading and trailing
    // delimiters, a cr/lf run, empty lines vanishing, extreme byte values, tab not live
    byte_stream = '{8'h20, "a", "b", 8'h20, 8'h20, "c", 8'h20, ByteCr, ByteLf, ByteLf,
                    ByteCr, 8'h00, 8'hff, 8'h09, ByteLf};
    drain();

    // http mode, count past four, cr as a delimiter (never one)
    set_config(1'b1, 3'd7, 8'h09, ByteCr, 8'h2c, 8'hff);
    byte_stream = '{ByteCr, ByteLf, ByteLf, ByteCr, ByteCr, ByteLf, "x", 8'h2c, 8'hff, 8'h09,
                    "y", ByteLf};
    drain();

    // zero register in the middle of the list, plain mode
    set_config(1'b0, 3'd4, 8'h20, 8'h2c, 8'h00, 8'h41);
    queue_random();
    drain();

    // all four live, lf in the list, extremes of the byte range as delimiters
    set_config(1'b1, 3'd4, 8'hff, 8'h01, 8'h20, ByteLf);
    queue_random();
    drain();

    // no delimiters at all
    set_config(1'b1, 3'd0, 8'h20, 8'h09, 8'h2c, 8'h3b);
    queue_random();
    drain();

    // count five acts as four
    set_config(1'b0, 3'd5, 8'h80, 8'h7f, 8'h3a, 8'h3b);
    queue_random();
    drain();

    // first register zero disables the whole list
    set_config(1'b1, 3'd3, 8'h00, 8'h20, 8'h09, 8'h2c);
    queue_random();
    drain();

    // token count saturation on one very long line, with the receiver held off
    // long enough that the block backs up onto its input
    set_config(1'b0, 3'd2, 8'h20, 8'h2c, 8'($urandom), 8'($urandom));
    for (int unsigned k = 0; k < SatTokens; k++) begin
      byte_stream.push_back(text_byte());
      byte_stream.push_back(delim_byte());
    end
    byte_stream.push_back("z");
    byte_stream.push_back(ByteLf);
    queue_random();
    hold_req = 1'b1;
    drain();

    // full rate both sides, random delimiter set
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(1, 255)),
               8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(1, 255)));
    queue_random();
    drain();

    // back to random idling, a few fully random settings
    src_idle_pct = 20;
    snk_idle_pct = 20;
    repeat (4) begin
      set_config(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
      queue_random();
      drain();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (err_count == 0 && owed_class.size() == 0) begin
      $display("line_and_token_splitter verification clean");
    end else begin
      $display("line_and_token_splitter verification failed");
    end
    $finish;
  end

endmodule
